@@ rtl/sps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sandpile grid sweep block.
package sps_pkg;

    localparam int NB_N = 8;
    localparam int TOPPLE_W = 11;
    localparam logic [7:0] TOPPLE_LIMIT = 8'd8;
    localparam logic [7:0] TOPPLE_CLEAR = 8'd16;
    localparam logic [7:0] GRAIN_MAX = 8'd255;
    localparam logic [TOPPLE_W-1:0] TOPPLE_MAX = 11'd2047;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SINK  = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [4:0] row;
        logic [4:0] col;
        logic [7:0] grains;
    } t_in_item;

    typedef struct packed {
        logic [TOPPLE_W-1:0] topple_count;
        logic                stable;
        logic [7:0]          cell_grains;
        logic                cell_is_sink;
    } t_out_item;

    typedef struct packed {
        logic       sink;
        logic [7:0] grains;
    } t_cell;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_NBR,
        ST_ACC,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        OFS_DEC,
        OFS_KEEP,
        OFS_INC
    } t_ofs;

    typedef struct packed {
        logic       found;
        logic [2:0] idx;
    } t_pick;

    localparam t_ofs NB_DR [NB_N] = '{OFS_DEC, OFS_DEC, OFS_DEC, OFS_KEEP,
                                      OFS_KEEP, OFS_INC, OFS_INC, OFS_INC};
    localparam t_ofs NB_DC [NB_N] = '{OFS_DEC, OFS_KEEP, OFS_INC, OFS_DEC,
                                      OFS_INC, OFS_DEC, OFS_KEEP, OFS_INC};

    // lowest set bit of a neighbour mask
    function automatic t_pick first_set(input logic [NB_N-1:0] mask);
        t_pick p;
        p = '0;
        for (int i = NB_N - 1; i >= 0; i--) begin
            if (mask[i]) begin
                p.found = 1'b1;
                p.idx   = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/sps_cell_mem.sv @@
`timescale 1ns / 1ps
// Cell store: one write and one registered read per cycle, with write-to-read bypass.
module sps_cell_mem import sps_pkg::*; #(
    parameter int GRID_SIDE = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    i_waddr,
    input  t_cell                                     i_wdata,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    i_raddr,
    output t_cell                                     o_rdata
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;

    t_cell r_mem [CELLS];
    t_cell r_rdata;
    t_cell r_fwd_data;
    logic  r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata    <= r_mem[i_raddr];
        r_fwd_hit  <= i_we && (i_waddr == i_raddr);
        r_fwd_data <= i_wdata;
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_rdata;

endmodule

@@ rtl/sps_nbr.sv @@
`timescale 1ns / 1ps
// Moore neighbour decode: in-grid mask and two neighbour addresses of a cell.
module sps_nbr import sps_pkg::*; #(
    parameter int GRID_SIDE = 32
) (
    input  logic [$clog2(GRID_SIDE)-1:0]              i_row,
    input  logic [$clog2(GRID_SIDE)-1:0]              i_col,
    input  logic [2:0]                                i_idx_a,
    input  logic [2:0]                                i_idx_b,
    output logic [NB_N-1:0]                           o_mask,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    o_addr_a,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    o_addr_b
);

    localparam int RW = $clog2(GRID_SIDE);
    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);
    localparam logic [RW-1:0] LAST = RW'(GRID_SIDE - 1);

    function automatic logic ofs_ok(input logic [RW-1:0] pos, input t_ofs ofs);
        logic ok;
        unique case (ofs)
            OFS_DEC: ok = (pos != '0);
            OFS_INC: ok = (pos != LAST);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    function automatic logic [RW-1:0] ofs_apply(input logic [RW-1:0] pos, input t_ofs ofs);
        logic [RW-1:0] p;
        unique case (ofs)
            OFS_DEC: p = pos - RW'(1);
            OFS_INC: p = pos + RW'(1);
            default: p = pos;
        endcase
        return p;
    endfunction

    function automatic logic [AW-1:0] nb_addr(input logic [RW-1:0] row,
                                              input logic [RW-1:0] col,
                                              input logic [2:0]    idx);
        logic [RW-1:0] nr;
        logic [RW-1:0] nc;
        nr = ofs_apply(row, NB_DR[idx]);
        nc = ofs_apply(col, NB_DC[idx]);
        return AW'(nr) * AW'(GRID_SIDE) + AW'(nc);
    endfunction

    always_comb begin
        for (int i = 0; i < NB_N; i++) begin
            o_mask[i] = ofs_ok(i_row, NB_DR[i]) && ofs_ok(i_col, NB_DC[i]);
        end
    end

    assign o_addr_a = nb_addr(i_row, i_col, i_idx_a);
    assign o_addr_b = nb_addr(i_row, i_col, i_idx_b);

endmodule

@@ rtl/sps_ctrl.sv @@
`timescale 1ns / 1ps
// Command sequencer: clearing pass, raster sweep with neighbour updates, cell access.
module sps_ctrl import sps_pkg::*; #(
    parameter int GRID_SIDE = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  t_in_item                                  i_in_data,
    output logic                                      o_res_valid,
    output t_out_item                                 o_res,
    input  logic                                      i_res_take,
    output logic                                      o_mem_we,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    o_mem_waddr,
    output t_cell                                     o_mem_wdata,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]    o_mem_raddr,
    input  t_cell                                     i_mem_rdata
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int RW    = $clog2(GRID_SIDE);
    localparam int AW    = $clog2(CELLS);
    localparam int UW    = $clog2(CELLS + 1);

    t_state              r_state, n_state;
    t_in_item            r_item;
    logic                r_ok;
    logic [AW-1:0]       r_iaddr;
    logic [RW-1:0]       r_srow, n_srow;
    logic [RW-1:0]       r_scol, n_scol;
    logic [AW-1:0]       r_saddr, n_saddr;
    logic [2:0]          r_nidx, n_nidx;
    logic [TOPPLE_W-1:0] r_topples, n_topples;
    logic [UW-1:0]       r_unstable, n_unstable;
    t_out_item           r_res, n_res;

    logic                accept;
    logic                in_ok;
    logic [AW-1:0]       in_addr;
    logic                topple;
    logic                last_cell;
    logic                scol_end;
    logic                advance;
    logic [NB_N-1:0]     nb_mask;
    logic [NB_N-1:0]     pick_mask;
    t_pick               pick;
    logic [AW-1:0]       nb_addr_a;
    logic [AW-1:0]       nb_addr_b;
    logic                new_unst;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign in_ok     = (int'(i_in_data.row) < GRID_SIDE) && (int'(i_in_data.col) < GRID_SIDE);
    assign in_addr   = AW'(RW'(i_in_data.row)) * AW'(GRID_SIDE) + AW'(RW'(i_in_data.col));
    assign topple    = !i_mem_rdata.sink && (i_mem_rdata.grains > TOPPLE_LIMIT);
    assign last_cell = (r_saddr == AW'(CELLS - 1));
    assign scol_end  = (r_scol == RW'(GRID_SIDE - 1));
    assign pick_mask = (r_state == ST_NBR) ? (nb_mask & (8'hFE << r_nidx)) : nb_mask;
    assign pick      = first_set(pick_mask);
    assign new_unst  = (r_item.grains > TOPPLE_LIMIT);

    assign advance = ((r_state == ST_SCAN) && !topple && !last_cell) ||
                     ((r_state == ST_NBR) && !pick.found && !last_cell);

    sps_nbr #(
        .GRID_SIDE(GRID_SIDE)
    ) u_nbr (
        .i_row    (r_srow),
        .i_col    (r_scol),
        .i_idx_a  (r_nidx),
        .i_idx_b  (pick.idx),
        .o_mask   (nb_mask),
        .o_addr_a (nb_addr_a),
        .o_addr_b (nb_addr_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (last_cell) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.command == CMD_SWEEP) n_state = ST_SCAN;
                    else if (in_ok)                     n_state = ST_ACC;
                    else                                n_state = ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (topple)         n_state = ST_NBR;
                else if (last_cell) n_state = r_ok ? ST_ACC : ST_RESULT;
            end
            ST_NBR: begin
                if (!pick.found) begin
                    if (last_cell) n_state = r_ok ? ST_ACC : ST_RESULT;
                    else           n_state = ST_SCAN;
                end
            end
            ST_ACC: n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_res_take) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // memory control
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_saddr;
        o_mem_wdata = '0;
        o_mem_raddr = r_saddr;
        unique case (r_state)
            ST_CLEAR: o_mem_we = 1'b1;
            ST_IDLE: begin
                o_mem_raddr = (i_in_data.command == CMD_SWEEP) ? '0 : in_addr;
            end
            ST_SCAN: begin
                if (topple) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = '{sink: 1'b0, grains: i_mem_rdata.grains - TOPPLE_LIMIT};
                    o_mem_raddr = nb_addr_b;
                end else if (last_cell) begin
                    o_mem_raddr = r_iaddr;
                end else begin
                    o_mem_raddr = r_saddr + AW'(1);
                end
            end
            ST_NBR: begin
                o_mem_waddr = nb_addr_a;
                if (!i_mem_rdata.sink && (i_mem_rdata.grains != GRAIN_MAX)) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = '{sink: 1'b0, grains: i_mem_rdata.grains + 8'd1};
                end
                if (pick.found)     o_mem_raddr = nb_addr_b;
                else if (last_cell) o_mem_raddr = r_iaddr;
                else                o_mem_raddr = r_saddr + AW'(1);
            end
            ST_ACC: begin
                o_mem_waddr = r_iaddr;
                if (r_item.command == CMD_WRITE) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = '{sink: 1'b0, grains: r_item.grains};
                end else if (r_item.command == CMD_SINK) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = '{sink: 1'b1, grains: i_mem_rdata.grains};
                end
            end
            default: ;
        endcase
    end

    // count of non-sink cells above the limit, kept in step with every write
    always_comb begin
        n_unstable = r_unstable;
        unique case (r_state)
            ST_CLEAR: n_unstable = '0;
            ST_SCAN: begin
                if (topple && (i_mem_rdata.grains <= TOPPLE_CLEAR)) begin
                    n_unstable = r_unstable - UW'(1);
                end
            end
            ST_NBR: begin
                if (!i_mem_rdata.sink && (i_mem_rdata.grains == TOPPLE_LIMIT)) begin
                    n_unstable = r_unstable + UW'(1);
                end
            end
            ST_ACC: begin
                if (r_item.command == CMD_WRITE) begin
                    n_unstable = r_unstable - UW'(topple) + UW'(new_unst);
                end else if (r_item.command == CMD_SINK) begin
                    n_unstable = r_unstable - UW'(topple);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_res = r_res;
        if (accept && (i_in_data.command != CMD_SWEEP) && !in_ok) begin
            n_res = '{topple_count: '0, stable: (r_unstable == '0),
                      cell_grains: '0, cell_is_sink: 1'b0};
        end else if ((n_state == ST_RESULT) && (r_state != ST_RESULT) && (r_state != ST_ACC)
                     && (r_state != ST_IDLE)) begin
            n_res = '{topple_count: r_topples, stable: (n_unstable == '0),
                      cell_grains: '0, cell_is_sink: 1'b0};
        end else if (r_state == ST_ACC) begin
            n_res.topple_count = r_topples;
            n_res.stable       = (n_unstable == '0);
            case (r_item.command)
                CMD_WRITE: begin
                    n_res.cell_grains  = r_item.grains;
                    n_res.cell_is_sink = 1'b0;
                end
                CMD_SINK: begin
                    n_res.cell_grains  = i_mem_rdata.grains;
                    n_res.cell_is_sink = 1'b1;
                end
                default: begin
                    n_res.cell_grains  = i_mem_rdata.grains;
                    n_res.cell_is_sink = i_mem_rdata.sink;
                end
            endcase
        end
    end

    always_comb begin
        n_saddr   = r_saddr;
        n_srow    = r_srow;
        n_scol    = r_scol;
        n_nidx    = r_nidx;
        n_topples = r_topples;
        if (r_state == ST_CLEAR) begin
            n_saddr = r_saddr + AW'(1);
        end else if (accept) begin
            n_saddr   = '0;
            n_srow    = '0;
            n_scol    = '0;
            n_topples = '0;
        end else if (advance) begin
            n_saddr = r_saddr + AW'(1);
            n_scol  = scol_end ? '0 : r_scol + RW'(1);
            n_srow  = scol_end ? r_srow + RW'(1) : r_srow;
        end
        if (((r_state == ST_SCAN) && topple) || (r_state == ST_NBR)) begin
            n_nidx = pick.idx;
        end
        if ((r_state == ST_SCAN) && topple && (r_topples != TOPPLE_MAX)) begin
            n_topples = r_topples + TOPPLE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_saddr    <= '0;
            r_unstable <= '0;
            r_topples  <= '0;
        end else begin
            r_state    <= n_state;
            r_saddr    <= n_saddr;
            r_unstable <= n_unstable;
            r_topples  <= n_topples;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srow <= n_srow;
        r_scol <= n_scol;
        r_nidx <= n_nidx;
        r_res  <= n_res;
        if (accept) begin
            r_item  <= i_in_data;
            r_ok    <= in_ok;
            r_iaddr <= in_addr;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_RESULT);
    assign o_res       = r_res;

    a_nbr_not_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NBR && o_mem_we) |-> (o_mem_waddr != r_saddr))
        else $error("neighbour update hit the toppling cell");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != ST_IDLE))
        else $error("transfer accepted without starting work");

    a_take_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_take) |=> (r_state == ST_IDLE && !o_res_valid))
        else $error("result not retired after transfer");

    a_topples_sweep_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_item.command != CMD_SWEEP) |-> (o_res.topple_count == '0))
        else $error("non-sweep command reported topples");

endmodule

@@ rtl/sandpile_grid_sweep.sv @@
`timescale 1ns / 1ps
// Sandpile grid sweep: commands in, one result per command out.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one command per
// transfer: write grains, mark sink, run one raster sweep, or read a cell.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns one result
// per command: topple count, grid stability and the addressed cell.
// Grain counts and sink marks live in one single-port-read memory of
// GRID_SIDE*GRID_SIDE entries; the sequencer reads, modifies and writes back.
// Write, mark and read pass through ST_ACC and ST_RESULT to the output
// register; an address outside the grid goes straight to ST_RESULT. A sweep
// scans all GRID_SIDE*GRID_SIDE cells and updates each in-grid neighbour of
// every cell that topples (at most 8), one cell or one neighbour per cycle.
// A new command is taken once the previous result has moved to the output
// register, even while that result is still stalled there.
// After reset the memory is cleared in a pass over all GRID_SIDE*GRID_SIDE
// cells, during which o_in_stall stays high. A stalled result holds its value.
module sandpile_grid_sweep import sps_pkg::*; #(
    parameter int GRID_SIDE = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_cell         mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_cell         mem_rdata;
    logic          res_valid;
    t_out_item     res;
    logic          res_take;
    logic          r_out_valid;
    t_out_item     r_out_data;

    sps_cell_mem #(
        .GRID_SIDE(GRID_SIDE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sps_ctrl #(
        .GRID_SIDE(GRID_SIDE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ dv/sandpile_grid_sweep_checker.sv @@
`timescale 1ns / 1ps
// Checker for the sandpile grid sweep: mirrors the grid, predicts and compares every result.
module sandpile_grid_sweep_checker import sps_pkg::*; #(
    parameter int GRID_SIDE = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic [7:0] grain_map [GRID_SIDE][GRID_SIDE];
    logic       sink_map  [GRID_SIDE][GRID_SIDE];
    t_out_item  result_q  [$];
    int         fails = 0;

    function automatic bit in_grid(input int r, input int c);
        return r >= 0 && c >= 0 && r < GRID_SIDE && c < GRID_SIDE;
    endfunction

    function automatic t_out_item step_grid(input t_in_item it);
        t_out_item res;
        int        r;
        int        c;
        bit        hit;
        r   = int'(it.row);
        c   = int'(it.col);
        hit = in_grid(r, c);
        res = '0;
        case (it.command)
            CMD_WRITE: begin
                if (hit) begin
                    grain_map[r][c] = it.grains;
                    sink_map[r][c]  = 1'b0;
                end
            end
            CMD_SINK: begin
                if (hit) sink_map[r][c] = 1'b1;
            end
            CMD_SWEEP: begin
                // raster order, in place
                for (int sr = 0; sr < GRID_SIDE; sr++) begin
                    for (int sc = 0; sc < GRID_SIDE; sc++) begin
                        if (!sink_map[sr][sc] && grain_map[sr][sc] > TOPPLE_LIMIT) begin
                            for (int dr = -1; dr <= 1; dr++) begin
                                for (int dc = -1; dc <= 1; dc++) begin
                                    if ((dr != 0 || dc != 0) && in_grid(sr + dr, sc + dc)) begin
                                        if (!sink_map[sr+dr][sc+dc] &&
                                            grain_map[sr+dr][sc+dc] != GRAIN_MAX)
                                            grain_map[sr+dr][sc+dc] =
                                                grain_map[sr+dr][sc+dc] + 8'd1;
                                    end
                                end
                            end
                            grain_map[sr][sc] = grain_map[sr][sc] - TOPPLE_LIMIT;
                            if (res.topple_count != TOPPLE_MAX)
                                res.topple_count = res.topple_count + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.stable = 1'b1;
        for (int sr = 0; sr < GRID_SIDE; sr++)
            for (int sc = 0; sc < GRID_SIDE; sc++)
                if (!sink_map[sr][sc] && grain_map[sr][sc] > TOPPLE_LIMIT)
                    res.stable = 1'b0;
        if (hit) begin
            res.cell_grains  = grain_map[r][c];
            res.cell_is_sink = sink_map[r][c];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_SIDE; r++) begin
                for (int c = 0; c < GRID_SIDE; c++) begin
                    grain_map[r][c] = '0;
                    sink_map[r][c]  = 1'b0;
                end
            end
            result_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with no command waiting");
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    if (i_out_data.topple_count !== want.topple_count) begin
                        $error("topple_count expected %0d actual %0d",
                               want.topple_count, i_out_data.topple_count);
                        fails++;
                    end
                    if (i_out_data.stable !== want.stable) begin
                        $error("stable expected %0d actual %0d",
                               want.stable, i_out_data.stable);
                        fails++;
                    end
                    if (i_out_data.cell_grains !== want.cell_grains) begin
                        $error("cell_grains expected %0d actual %0d",
                               want.cell_grains, i_out_data.cell_grains);
                        fails++;
                    end
                    if (i_out_data.cell_is_sink !== want.cell_is_sink) begin
                        $error("cell_is_sink expected %0d actual %0d",
                               want.cell_is_sink, i_out_data.cell_is_sink);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                result_q.push_back(step_grid(i_in_data));
        end
        o_pending    <= result_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ dv/sandpile_grid_sweep_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the sandpile grid sweep: reset, command stimulus, idling and verdict.
module sandpile_grid_sweep_tb;
    import sps_pkg::*;

    localparam int GRID_SIDE   = 32;
    localparam int CELLS       = GRID_SIDE * GRID_SIDE;
    localparam int N_ITEMS     = 580;
    localparam int QUIET_ITEMS = 60;
    // every command a sweep with every cell toppling, plus gaps, stalls and the clear pass
    localparam int CYCLE_LIMIT =
        3 * (CELLS + (N_ITEMS + 40) * (CELLS + 3 + NB_N * CELLS + 8));

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    int fail_count;
    int pending;
    int cycles     = 0;
    int stall_left = 0;
    bit quiet      = 1'b0;
    bit drained    = 1'b0;
    int sent       = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    sandpile_grid_sweep #(
        .GRID_SIDE (GRID_SIDE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    sandpile_grid_sweep_checker #(
        .GRID_SIDE (GRID_SIDE)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sandpile_grid_sweep_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left  <= $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic t_in_item cmd_item(input t_cmd op, input int r, input int c,
                                          input int g);
        t_in_item it;
        it.command = op;
        it.row     = 5'(r);
        it.col     = 5'(c);
        it.grains  = 8'(g);
        return it;
    endfunction

    function automatic int near(input int b);
        int v;
        v = b + $urandom_range(0, 2);
        return (v > GRID_SIDE - 1) ? GRID_SIDE - 1 : v;
    endfunction

    function automatic int pick_grains();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom_range(9, 40);
            2:       return $urandom_range(200, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        if (sent == N_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // a small patch of writes, maybe a sink, then sweeps and a read nearby
    task automatic run_episode();
        int br;
        int bc;
        br = $urandom_range(0, GRID_SIDE - 1);
        bc = $urandom_range(0, GRID_SIDE - 1);
        if ($urandom_range(0, 3) == 0) br = $urandom_range(0, 1) ? 0 : GRID_SIDE - 3;
        if ($urandom_range(0, 3) == 0) bc = $urandom_range(0, 1) ? 0 : GRID_SIDE - 3;
        repeat ($urandom_range(2, 6))
            send_item(cmd_item(CMD_WRITE, near(br), near(bc), pick_grains()));
        if ($urandom_range(0, 2) == 0)
            send_item(cmd_item(CMD_SINK, near(br), near(bc), $urandom_range(0, 255)));
        repeat ($urandom_range(1, 3))
            send_item(cmd_item(CMD_SWEEP, near(br), near(bc), $urandom_range(0, 255)));
        send_item(cmd_item(CMD_READ, near(br), near(bc), $urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(cmd_item(CMD_READ,  0,  0,   0));
        send_item(cmd_item(CMD_READ, 31, 31, 255));
        send_item(cmd_item(CMD_WRITE, 0,  0, 255));
        send_item(cmd_item(CMD_WRITE, 0,  1, 255));
        send_item(cmd_item(CMD_SINK,  1,  1,   0));
        send_item(cmd_item(CMD_WRITE, 1,  0,   0));
        send_item(cmd_item(CMD_READ,  0,  0,   0));
        send_item(cmd_item(CMD_SWEEP, 0,  1,   0));
        send_item(cmd_item(CMD_READ,  1,  1,   0));
        // write over a sink clears the mark, marking again keeps the count
        send_item(cmd_item(CMD_WRITE, 1,  1,   5));
        send_item(cmd_item(CMD_SINK,  1,  1, 255));
        send_item(cmd_item(CMD_READ,  1,  1,   0));
        send_item(cmd_item(CMD_SINK, 31, 31,   0));
        send_item(cmd_item(CMD_WRITE, 31, 30,  9));
        send_item(cmd_item(CMD_WRITE, 30, 31, 200));
        send_item(cmd_item(CMD_WRITE, 31,  0,  8));
        send_item(cmd_item(CMD_WRITE, 0, 31,   9));
        send_item(cmd_item(CMD_SWEEP, 31, 31,  0));
        send_item(cmd_item(CMD_WRITE, 21, 10, 170));
        send_item(cmd_item(CMD_WRITE, 10, 21,  85));
        send_item(cmd_item(CMD_SWEEP, 10, 21, 255));
        send_item(cmd_item(CMD_SWEEP, 0,  0,   0));
        send_item(cmd_item(CMD_READ, 10, 21,   0));

        while (sent < N_ITEMS) begin
            if ($urandom_range(0, 4) == 0)
                send_item(cmd_item(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 31),
                                   $urandom_range(0, 31), $urandom_range(0, 255)));
            else
                run_episode();
            if (!drained && sent >= N_ITEMS / 3) begin
                drained = 1'b1;
                drain();
            end
        end

        drain();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("sandpile_grid_sweep_tb passed");
        else
            $display("sandpile_grid_sweep_tb failed");
        $finish;
    end

endmodule
